// ===== src/assert_macros.svh =====
// Assertion macros used by the checker file.
// Macros take label, clock, reset (not _ALWAYS), antecedent, consequent and message.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is high
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, off while reset is high
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// Next-cycle implication, checked during reset too
`define ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/slt_pkg.sv =====
// ----------------------------------------------------------------------------
// slt_pkg
// Shared constants and types for the stretch table display converter.
// ----------------------------------------------------------------------------
package slt_pkg;

  // Table index width and depth
  localparam int SAMPLE_BITS = 16;
  localparam int TABLE_DEPTH = 1 << SAMPLE_BITS;

  // Field widths
  localparam int SAMPLE_W = 16;
  localparam int BYTE_W   = 8;
  localparam int GAIN_W   = 16;
  localparam int PROD_W   = BYTE_W + GAIN_W;
  localparam int PIXEL_W  = 32;
  localparam int IN_W     = 4 * SAMPLE_W + BYTE_W;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [BYTE_W-1:0] BYTE_MAX = 8'hFF;
  localparam logic [BYTE_W-1:0] ALPHA    = 8'hFF;

  // Request kinds carried in tuser
  localparam logic REQ_PIXEL = 1'b0;
  localparam logic REQ_TABLE = 1'b1;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COLOR_MODE  = 3'd0,
    CFG_TINT_ENABLE = 3'd1,
    CFG_TINT_RED    = 3'd2,
    CFG_TINT_GREEN  = 3'd3,
    CFG_TINT_BLUE   = 3'd4
  } cfg_index_t;

  localparam logic [GAIN_W-1:0] GAIN_UNITY = 16'd256;

  // Per-lane control from the configuration registers
  typedef struct packed {
    logic color_mode;
    logic tint_on;
  } lane_ctrl_t;

endpackage

// ===== src/slt_lane.sv =====
// ----------------------------------------------------------------------------
// slt_lane
// One channel lane: private copy of the stretch table, registered lookup,
// Q8.8 tint multiply and saturation.
// ----------------------------------------------------------------------------
module slt_lane import slt_pkg::*; (
  input  logic                   clk,
  input  logic                   en,
  input  logic                   wr_en,
  input  logic [SAMPLE_BITS-1:0] wr_addr,
  input  logic [BYTE_W-1:0]      wr_data,
  input  logic [SAMPLE_W-1:0]    sample,
  input  logic [SAMPLE_W-1:0]    mono_sample,
  input  lane_ctrl_t             ctrl,
  input  logic [GAIN_W-1:0]      gain,
  output logic [BYTE_W-1:0]      byte_out
);

  logic [BYTE_W-1:0]      mem [TABLE_DEPTH];
  logic [SAMPLE_BITS-1:0] rd_addr;
  logic [BYTE_W-1:0]      rd_byte;
  logic [BYTE_W-1:0]      raw_byte;
  logic [PROD_W-1:0]      prod;

  // Mono mode reads every lane at the mono sample
  assign rd_addr = ctrl.color_mode ? sample[SAMPLE_BITS-1:0] : mono_sample[SAMPLE_BITS-1:0];

  // Table write and registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (en) begin
      rd_byte <= mem[rd_addr];
    end
  end

  // Multiply by the gain, keep the raw byte alongside
  always_ff @(posedge clk) begin
    if (en) begin
      prod     <= PROD_W'(rd_byte) * PROD_W'(gain);
      raw_byte <= rd_byte;
    end
  end

  // With tint on, drop the fraction and saturate at full scale; else pass the raw byte
  always_comb begin
    if (ctrl.tint_on) begin
      byte_out = (prod[PROD_W-1:2*BYTE_W] != '0) ? BYTE_MAX : prod[2*BYTE_W-1:BYTE_W];
    end else begin
      byte_out = raw_byte;
    end
  end

endmodule

// ===== src/slt_merge.sv =====
// ----------------------------------------------------------------------------
// slt_merge
// Combine the three lane bytes into a BGRA pixel and hold it in the output
// register until the receiver takes it.
// ----------------------------------------------------------------------------
module slt_merge import slt_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               advance,
  input  logic               in_valid,
  input  logic [BYTE_W-1:0]  red_byte,
  input  logic [BYTE_W-1:0]  green_byte,
  input  logic [BYTE_W-1:0]  blue_byte,
  output logic               out_valid,
  output logic [PIXEL_W-1:0] out_pixel
);

  // Load the output register whenever the pipeline moves
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_pixel <= {ALPHA, red_byte, green_byte, blue_byte};
    end
  end

endmodule

// ===== src/stretch_lut_tint_to_bgra_top.sv =====
// ----------------------------------------------------------------------------
// stretch_lut_tint_to_bgra_top
// Maps 16-bit pixel samples through a stretch table to display bytes, with
// optional per-channel tint in mono mode, and packs them as BGRA.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream s_*: tuser 0 carries a pixel, tuser 1 loads one table entry.
//   Table loads give no output item. Each pixel gives one 32-bit BGRA item
//   on m_* with alpha 255.
//   Config port: cfg_we writes cfg_data to register cfg_index; write only
//   while no pixel is in flight.
//   An accepted pixel goes through the table read, the tint multiply and the
//   output register to m_tvalid. Throughput: one item per cycle when not
//   stalled; each lane has its own copy of the table, so three reads run at once.
//   A table load is visible to a pixel accepted in the very next cycle.
//   Reset clears control and restores configuration defaults (mono, no tint,
//   unity gains); the table contents stay undefined until loaded.
//   Stall: while m_tvalid is high and m_tready low the whole pipeline holds,
//   and s_tready drops in that same cycle.
// ----------------------------------------------------------------------------
module stretch_lut_tint_to_bgra_top import slt_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // [15:0] red_sample, [31:16] green_sample, [47:32] blue_sample,
  // [63:48] table_addr, [71:64] table_value
  input  logic [IN_W-1:0]       s_tdata,
  // [0] req_type
  input  logic                  s_tuser,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // [31:0] packed_pixel
  output logic [PIXEL_W-1:0]    m_tdata,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic              color_mode;
  logic              tint_enable;
  logic [GAIN_W-1:0] tint_red;
  logic [GAIN_W-1:0] tint_green;
  logic [GAIN_W-1:0] tint_blue;

  logic              advance;
  logic              accept;
  logic              table_wr;
  logic              v1;
  logic              v2;
  lane_ctrl_t        ctrl;

  logic [SAMPLE_W-1:0]    red_sample;
  logic [SAMPLE_W-1:0]    green_sample;
  logic [SAMPLE_W-1:0]    blue_sample;
  logic [SAMPLE_BITS-1:0] table_addr;
  logic [BYTE_W-1:0]      table_value;
  logic [BYTE_W-1:0]      red_byte;
  logic [BYTE_W-1:0]      green_byte;
  logic [BYTE_W-1:0]      blue_byte;

  // Unpack the input item
  assign red_sample   = s_tdata[SAMPLE_W-1:0];
  assign green_sample = s_tdata[2*SAMPLE_W-1:SAMPLE_W];
  assign blue_sample  = s_tdata[3*SAMPLE_W-1:2*SAMPLE_W];
  assign table_addr   = s_tdata[3*SAMPLE_W+SAMPLE_BITS-1:3*SAMPLE_W];
  assign table_value  = s_tdata[IN_W-1:4*SAMPLE_W];

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      color_mode  <= 1'b0;
      tint_enable <= 1'b0;
      tint_red    <= GAIN_UNITY;
      tint_green  <= GAIN_UNITY;
      tint_blue   <= GAIN_UNITY;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_COLOR_MODE:  color_mode  <= cfg_data[0];
        CFG_TINT_ENABLE: tint_enable <= cfg_data[0];
        CFG_TINT_RED:    tint_red    <= cfg_data;
        CFG_TINT_GREEN:  tint_green  <= cfg_data;
        CFG_TINT_BLUE:   tint_blue   <= cfg_data;
        default: ;
      endcase
    end
  end

  assign ctrl = '{color_mode: color_mode, tint_on: !color_mode && tint_enable};

  // Move the pipeline whenever the output register is free or being taken
  assign advance  = !m_tvalid || m_tready;
  assign s_tready = advance;
  assign accept   = s_tvalid && s_tready;
  assign table_wr = accept && (s_tuser == REQ_TABLE);

  // Track pixel items through read and multiply stages
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else if (advance) begin
      v1 <= accept && (s_tuser == REQ_PIXEL);
      v2 <= v1;
    end
  end

  slt_lane u_lane_red (
    .clk         (clk),
    .en          (advance),
    .wr_en       (table_wr),
    .wr_addr     (table_addr),
    .wr_data     (table_value),
    .sample      (red_sample),
    .mono_sample (red_sample),
    .ctrl        (ctrl),
    .gain        (tint_red),
    .byte_out    (red_byte)
  );

  slt_lane u_lane_green (
    .clk         (clk),
    .en          (advance),
    .wr_en       (table_wr),
    .wr_addr     (table_addr),
    .wr_data     (table_value),
    .sample      (green_sample),
    .mono_sample (red_sample),
    .ctrl        (ctrl),
    .gain        (tint_green),
    .byte_out    (green_byte)
  );

  slt_lane u_lane_blue (
    .clk         (clk),
    .en          (advance),
    .wr_en       (table_wr),
    .wr_addr     (table_addr),
    .wr_data     (table_value),
    .sample      (blue_sample),
    .mono_sample (red_sample),
    .ctrl        (ctrl),
    .gain        (tint_blue),
    .byte_out    (blue_byte)
  );

  slt_merge u_merge (
    .clk        (clk),
    .rst        (rst),
    .advance    (advance),
    .in_valid   (v2),
    .red_byte   (red_byte),
    .green_byte (green_byte),
    .blue_byte  (blue_byte),
    .out_valid  (m_tvalid),
    .out_pixel  (m_tdata)
  );

endmodule

// ===== src/slt_checker.sv =====
// ----------------------------------------------------------------------------
// slt_checker
// Port-level checks on the stretch table converter, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module slt_checker import slt_pkg::*; (
  input logic                  clk,
  input logic                  rst,
  input logic                  s_tvalid,
  input logic                  s_tready,
  input logic                  s_tuser,
  input logic                  m_tvalid,
  input logic                  m_tready,
  input logic [PIXEL_W-1:0]    m_tdata
);

  // Stalled output holds its pixel
  `ASSERT_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "output changed while stalled")

  // Every output pixel carries opaque alpha
  `ASSERT_IMPLY(a_alpha, clk, rst, m_tvalid, m_tdata[31:24] == ALPHA, "alpha byte not 255")

  // Input is open exactly when the output side can move
  `ASSERT_IMPLY(a_ready, clk, rst, 1'b1, s_tready == (!m_tvalid || m_tready), "input ready does not follow output")

  // A pixel with no stall behind it reaches the output through the read and multiply stages
  `ASSERT_NEXT(a_latency, clk, rst, (s_tvalid && s_tready && (s_tuser == REQ_PIXEL)) ##1 m_tready ##1 m_tready, m_tvalid, "pixel did not arrive in time")

  // Reset empties the output
  `ASSERT_NEXT_ALWAYS(a_reset, clk, rst, !m_tvalid, "output valid after reset")

endmodule

bind stretch_lut_tint_to_bgra_top slt_checker u_slt_checker (.*);
